// ===== rtl/core/daq_pkg.sv =====
// Shared widths, codes and record types of the DAG ancestor query block.
`default_nettype none
package daq_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned SLOT_W = 12;
  localparam int unsigned ID_W   = 11;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned NC_W   = 11;
  localparam int unsigned SC_W   = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned DEF_MAX_NODES   = 1024;
  localparam int unsigned DEF_MAX_EDGES   = 4096;
  localparam int unsigned DEF_MAX_STAGES  = 256;
  localparam int unsigned DEF_MAX_RESULTS = 64;

  localparam logic [OP_W-1:0] OP_LOAD_NODE  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_EDGE  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_STAGE = 3'd2;
  localparam logic [OP_W-1:0] OP_PARENTS    = 3'd3;
  localparam logic [OP_W-1:0] OP_PRED       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_TOO_SMALL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 1'd1;

  typedef struct packed {
    logic              ev;
    logic [SLOT_W-1:0] first;
    logic [CNT_W-1:0]  total;
  } node_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] required;
    logic [ID_W-1:0]  item_id;
    logic             item_valid;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/daq_if.sv =====
// Channel interfaces: query/load input, result output and register write.
`default_nettype none
interface daq_in_if import daq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SLOT_W-1:0] slot;
  logic              kind_is_evidence;
  logic [SLOT_W-1:0] list_start;
  logic [CNT_W-1:0]  list_count;
  logic [ID_W-1:0]   parent_ref;
  logic [ID_W-1:0]   stage_node;
  logic [ID_W-1:0]   query_key;
  logic              transitive;
  logic [CAP_W-1:0]  capacity;
  modport source (output valid, operation, slot, kind_is_evidence, list_start, list_count,
                  parent_ref, stage_node, query_key, transitive, capacity, input ready);
  modport sink (input valid, operation, slot, kind_is_evidence, list_start, list_count,
                parent_ref, stage_node, query_key, transitive, capacity, output ready);
endinterface

interface daq_out_if import daq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] required;
  logic [ID_W-1:0]  item_id;
  logic             item_valid;
  logic             last;
  modport source (output valid, status, required, item_id, item_valid, last, input ready);
  modport sink (input valid, status, required, item_id, item_valid, last, output ready);
endinterface

interface daq_cfg_if import daq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/daq_out_reg.sv =====
// Output register stage holding one result beat for the receiver.
`default_nettype none
module daq_out_reg import daq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t res_i,
  output logic      free_o,
  daq_out_if.source out_o
);

  logic full_q, full_d;
  res_t res_q;

  assign free_o = !full_q || out_o.ready;
  assign full_d = (push_i && free_o) ? 1'b1 : (out_o.ready ? 1'b0 : full_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = full_q;
  assign out_o.status     = res_q.status;
  assign out_o.required   = res_q.required;
  assign out_o.item_id    = res_q.item_id;
  assign out_o.item_valid = res_q.item_valid;
  assign out_o.last       = res_q.last;

endmodule
`default_nettype wire

// ===== rtl/core/dag_ancestor_query_top.sv =====
// Top level of the DAG ancestor query block: tables, sequencer and walk.
// Usage:
//   in_i carries load and query beats; ready is high only while the sequencer
//   is idle. Loads and unknown operations give no result.
//   out_o returns result beats through a one-entry output register; a stalled
//   receiver holds the sequencer at its next emit step, nothing is dropped.
//   cfg_i writes node_count (index 0) and stage_count (index 1); always ready.
// Query sequence:
//   A parents query reads the node record, reduces the list start modulo the
//   edge table depth, then reads and emits each edge of the list in turn.
//   A transitive query first clears the mark memory, then walks ids downward
//   from the input, following the edge list of the input and of every marked
//   node, then scans the ids below the input again while emitting. The single
//   read port of each table and the one mark memory keep these steps serial.
// Reset:
//   Clears the sequencer, both count registers and the output register; the
//   table memories are not cleared and must be loaded before they are read.
`default_nettype none
module dag_ancestor_query_top import daq_pkg::*; #(
  parameter int unsigned MAX_NODES   = DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES   = DEF_MAX_EDGES,
  parameter int unsigned MAX_STAGES  = DEF_MAX_STAGES,
  parameter int unsigned MAX_RESULTS = DEF_MAX_RESULTS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  daq_in_if.sink    in_i,
  daq_out_if.source out_o,
  daq_cfg_if.sink   cfg_i
);

  localparam int unsigned NIW = $clog2(MAX_NODES);
  localparam int unsigned EIW = $clog2(MAX_EDGES);
  localparam int unsigned SIW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned PW  = ((EIW > SLOT_W) ? EIW : SLOT_W) + 1;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_ONE  = 13'b0000000000010,
    S_STG  = 13'b0000000000100,
    S_NODE = 13'b0000000001000,
    S_NORM = 13'b0000000010000,
    S_ERD  = 13'b0000000100000,
    S_EACT = 13'b0000001000000,
    S_CLR  = 13'b0000010000000,
    S_WRD  = 13'b0000100000000,
    S_WCHK = 13'b0001000000000,
    S_FIN  = 13'b0010000000000,
    S_SRD  = 13'b0100000000000,
    S_SCHK = 13'b1000000000000
  } state_e;

  // Tables
  node_t           node_mem  [MAX_NODES];
  logic [ID_W-1:0] edge_mem  [MAX_EDGES];
  logic [ID_W-1:0] stage_mem [MAX_STAGES];
  logic            mark_mem  [MAX_NODES];

  node_t           node_rd_q;
  logic [ID_W-1:0] edge_rd_q;
  logic [ID_W-1:0] stage_rd_q;
  logic            mark_rd_q;

  state_e state_q, state_d;
  logic [NC_W-1:0]  node_count_q;
  logic [SC_W-1:0]  stage_count_q;
  logic             trans_q, trans_d;
  logic             first_q, first_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [ID_W-1:0]  inp_q, inp_d;
  logic [ID_W-1:0]  cur_q, cur_d;
  logic [ID_W-1:0]  sid_q, sid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [PW-1:0]    ptr_q, ptr_d;
  logic [NIW-1:0]   clr_q, clr_d;
  logic [ST_W-1:0]  ost_q, ost_d;
  logic [CNT_W-1:0] oreq_q, oreq_d;

  logic             node_re, mark_re, mark_we, mark_wv, edge_re, stage_re;
  logic [NIW-1:0]   node_ra, mark_ra, mark_wa;
  logic [EIW-1:0]   edge_ra;
  logic [SIW-1:0]   stage_ra;
  logic             push, out_free;
  res_t             res;

  logic in_acc;
  logic [CAP_W-1:0] cap_eff;

  function automatic logic node_ok(logic [ID_W-1:0] id, logic [NC_W-1:0] cnt, int unsigned mx);
    node_ok = (id != '0) && (32'(id) <= 32'(cnt)) && (32'(id) <= mx);
  endfunction

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cap_eff = (32'(in_i.capacity) > MAX_RESULTS) ? CAP_W'(MAX_RESULTS) : in_i.capacity;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= '0;
      stage_count_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_NODE_COUNT:  node_count_q  <= NC_W'(cfg_i.data);
        REG_STAGE_COUNT: stage_count_q <= SC_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Table writes from load beats, ignoring slots past each table, and registered table reads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (in_i.operation == OP_LOAD_NODE && 32'(in_i.slot) < MAX_NODES) begin
        node_mem[NIW'(in_i.slot)] <= '{ev: in_i.kind_is_evidence, first: in_i.list_start,
                                       total: in_i.list_count};
      end
      if (in_i.operation == OP_LOAD_EDGE && 32'(in_i.slot) < MAX_EDGES) begin
        edge_mem[EIW'(in_i.slot)] <= in_i.parent_ref;
      end
      if (in_i.operation == OP_LOAD_STAGE && 32'(in_i.slot) < MAX_STAGES) begin
        stage_mem[SIW'(in_i.slot)] <= in_i.stage_node;
      end
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_ra];
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[edge_ra];
    end
    if (stage_re) begin
      stage_rd_q <= stage_mem[stage_ra];
    end
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wv;
    end
    if (mark_re) begin
      mark_rd_q <= mark_mem[mark_ra];
    end
  end

  always_comb begin
    state_d = state_q;
    trans_d = trans_q;
    first_d = first_q;
    cap_d   = cap_q;
    inp_d   = inp_q;
    cur_d   = cur_q;
    sid_d   = sid_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    ptr_d   = ptr_q;
    clr_d   = clr_q;
    ost_d   = ost_q;
    oreq_d  = oreq_q;
    node_re = 1'b0;
    node_ra = NIW'(cur_q - ID_W'(1));
    mark_re = 1'b0;
    mark_ra = NIW'(cur_q - ID_W'(1));
    mark_we = 1'b0;
    mark_wa = clr_q;
    mark_wv = 1'b0;
    edge_re = 1'b0;
    edge_ra = EIW'(ptr_q);
    stage_re = 1'b0;
    stage_ra = SIW'(in_i.query_key - ID_W'(1));
    push = 1'b0;
    res  = '{status: ST_OK, required: cnt_q, item_id: '0, item_valid: 1'b0, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cap_d   = cap_eff;
          trans_d = in_i.transitive;
          if (in_i.operation == OP_PARENTS) begin
            trans_d = 1'b0;
            if (node_ok(in_i.query_key, node_count_q, MAX_NODES)) begin
              node_re = 1'b1;
              node_ra = NIW'(in_i.query_key - ID_W'(1));
              state_d = S_NODE;
            end else begin
              ost_d = ST_NOT_FOUND;
              oreq_d = '0;
              state_d = S_ONE;
            end
          end else if (in_i.operation == OP_PRED) begin
            if (in_i.query_key != '0 && 32'(in_i.query_key) <= 32'(stage_count_q)
                && 32'(in_i.query_key) <= MAX_STAGES) begin
              stage_re = 1'b1;
              state_d  = S_STG;
            end else begin
              ost_d = ST_NOT_FOUND;
              oreq_d = '0;
              state_d = S_ONE;
            end
          end
        end
      end
      S_ONE: begin
        push = 1'b1;
        res  = '{status: ost_q, required: oreq_q, item_id: '0, item_valid: 1'b0, last: 1'b1};
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_STG: begin
        if (!node_ok(stage_rd_q, node_count_q, MAX_NODES)) begin
          ost_d = ST_NOT_FOUND;
          oreq_d = '0;
          state_d = S_ONE;
        end else if (trans_q) begin
          inp_d = stage_rd_q;
          clr_d = '0;
          state_d = S_CLR;
        end else begin
          node_re = 1'b1;
          node_ra = NIW'(stage_rd_q - ID_W'(1));
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        if (CNT_W'(cap_q) < node_rd_q.total) begin
          ost_d = ST_TOO_SMALL;
          oreq_d = node_rd_q.total;
          state_d = S_ONE;
        end else if (node_rd_q.total == '0) begin
          ost_d = ST_OK;
          oreq_d = '0;
          state_d = S_ONE;
        end else begin
          ptr_d = PW'(node_rd_q.first);
          idx_d = '0;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        // reduce the list start modulo the edge table depth
        if (32'(ptr_q) >= MAX_EDGES) begin
          ptr_d = ptr_q - PW'(MAX_EDGES);
        end else begin
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        edge_re = 1'b1;
        state_d = S_EACT;
      end
      S_EACT: begin
        if (!trans_q) begin
          push = 1'b1;
          res  = '{status: ST_OK, required: node_rd_q.total, item_id: edge_rd_q,
                   item_valid: 1'b1, last: (idx_q + CNT_W'(1) == node_rd_q.total)};
        end else begin
          mark_we = (edge_rd_q != '0) && (32'(edge_rd_q) <= MAX_NODES);
          mark_wa = NIW'(edge_rd_q - ID_W'(1));
          mark_wv = 1'b1;
        end
        if (trans_q || out_free) begin
          idx_d = idx_q + CNT_W'(1);
          ptr_d = (32'(ptr_q) + 1 == MAX_EDGES) ? '0 : ptr_q + PW'(1);
          if (idx_q + CNT_W'(1) != node_rd_q.total) begin
            state_d = S_ERD;
          end else if (!trans_q) begin
            state_d = S_IDLE;
          end else if (cur_q == ID_W'(1)) begin
            state_d = S_FIN;
          end else begin
            cur_d = cur_q - ID_W'(1);
            state_d = S_WRD;
          end
        end
      end
      S_CLR: begin
        mark_we = 1'b1;
        if (32'(clr_q) == MAX_NODES - 1) begin
          cur_d   = inp_q;
          first_d = 1'b1;
          cnt_d   = '0;
          state_d = S_WRD;
        end else begin
          clr_d = clr_q + NIW'(1);
        end
      end
      S_WRD: begin
        node_re = 1'b1;
        mark_re = 1'b1;
        state_d = S_WCHK;
      end
      S_WCHK: begin
        if ((first_q || mark_rd_q) && node_rd_q.total != '0) begin
          if (!first_q && node_rd_q.ev) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          first_d = 1'b0;
          ptr_d = PW'(node_rd_q.first);
          idx_d = '0;
          state_d = S_NORM;
        end else begin
          if (!first_q && mark_rd_q && node_rd_q.ev) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          first_d = 1'b0;
          if (cur_q == ID_W'(1)) begin
            state_d = S_FIN;
          end else begin
            cur_d = cur_q - ID_W'(1);
            state_d = S_WRD;
          end
        end
      end
      S_FIN: begin
        if (CNT_W'(cap_q) < cnt_q) begin
          ost_d = ST_TOO_SMALL;
          oreq_d = cnt_q;
          state_d = S_ONE;
        end else if (cnt_q == '0) begin
          ost_d = ST_OK;
          oreq_d = '0;
          state_d = S_ONE;
        end else begin
          sid_d = ID_W'(1);
          idx_d = '0;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        node_re = 1'b1;
        node_ra = NIW'(sid_q - ID_W'(1));
        mark_re = 1'b1;
        mark_ra = NIW'(sid_q - ID_W'(1));
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (mark_rd_q && node_rd_q.ev) begin
          push = 1'b1;
          res  = '{status: ST_OK, required: cnt_q, item_id: sid_q, item_valid: 1'b1,
                   last: (idx_q + CNT_W'(1) == cnt_q)};
        end
        if (!(mark_rd_q && node_rd_q.ev) || out_free) begin
          if (mark_rd_q && node_rd_q.ev) begin
            idx_d = idx_q + CNT_W'(1);
          end
          if (sid_q + ID_W'(1) == inp_q) begin
            state_d = S_IDLE;
          end else begin
            sid_d = sid_q + ID_W'(1);
            state_d = S_SRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trans_q <= trans_d;
    first_q <= first_d;
    cap_q   <= cap_d;
    inp_q   <= inp_d;
    cur_q   <= cur_d;
    sid_q   <= sid_d;
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    ptr_q   <= ptr_d;
    clr_q   <= clr_d;
    ost_q   <= ost_d;
    oreq_q  <= oreq_d;
  end

  daq_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

// ===== verif/tb_dag_ancestor_query_top.sv =====
// Testbench of dag_ancestor_query_top: loads small graphs, runs queries, checks every result beat.
module tb_dag_ancestor_query_top;
  import daq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic              ev;
    logic [SLOT_W-1:0] start;
    logic [CNT_W-1:0]  cnt;
    logic [ID_W-1:0]   pref;
    logic [ID_W-1:0]   snode;
    logic [ID_W-1:0]   key;
    logic              trans;
    logic [CAP_W-1:0]  cap;
  } query_item_t;

  localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;

  class lineage_scoreboard;
    logic             node_ev[DEF_MAX_NODES];
    logic [SLOT_W-1:0] node_first[DEF_MAX_NODES];
    logic [CNT_W-1:0] node_total[DEF_MAX_NODES];
    logic [ID_W-1:0]  edge_mem[DEF_MAX_EDGES];
    logic [ID_W-1:0]  stage_mem[DEF_MAX_STAGES];
    bit               marks[DEF_MAX_NODES];
    int unsigned      node_cnt;
    int unsigned      stage_cnt;
    res_t             answer_q[$];
    int               errors;

    function new();
      node_cnt = 0;
      stage_cnt = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      if (idx == REG_NODE_COUNT) node_cnt = val & 11'h7ff;
      else stage_cnt = val & 9'h1ff;
    endfunction

    function bit node_ok(int unsigned id);
      return id != 0 && id <= node_cnt && id <= DEF_MAX_NODES;
    endfunction

    function void push(logic [ST_W-1:0] st, int unsigned req, int unsigned id, bit v, bit l);
      res_t r;
      r.status = st;
      r.required = req[CNT_W-1:0];
      r.item_id = id[ID_W-1:0];
      r.item_valid = v;
      r.last = l;
      answer_q.push_back(r);
    endfunction

    function int unsigned edge_of(int unsigned idx, int unsigned i);
      return edge_mem[(node_first[idx] + i) % DEF_MAX_EDGES];
    endfunction

    function void list_parents(int unsigned id, int unsigned cap);
      int unsigned t;
      if (!node_ok(id)) begin
        push(ST_NOT_FOUND, 0, 0, 0, 1);
        return;
      end
      t = node_total[id-1];
      if (cap < t) push(ST_TOO_SMALL, t, 0, 0, 1);
      else if (t == 0) push(ST_OK, 0, 0, 0, 1);
      else for (int unsigned i = 0; i < t; i++) push(ST_OK, t, edge_of(id-1, i), 1, i + 1 == t);
    endfunction

    function void mark_from(int unsigned idx);
      int unsigned p;
      for (int unsigned i = 0; i < node_total[idx]; i++) begin
        p = edge_of(idx, i);
        if (p != 0 && p <= DEF_MAX_NODES) marks[p-1] = 1;
      end
    endfunction

    function void list_ancestors(int unsigned src_id, int unsigned cap);
      int unsigned count;
      int unsigned n;
      count = 0;
      n = 0;
      if (!node_ok(src_id)) begin
        push(ST_NOT_FOUND, 0, 0, 0, 1);
        return;
      end
      mark_from(src_id - 1);
      for (int unsigned id = src_id - 1; id != 0; id--) begin
        if (marks[id-1]) begin
          if (node_ev[id-1]) count++;
          mark_from(id - 1);
        end
      end
      if (cap < count) push(ST_TOO_SMALL, count, 0, 0, 1);
      else if (count == 0) push(ST_OK, 0, 0, 0, 1);
      else for (int unsigned id = 1; id < src_id; id++) begin
        if (marks[id-1] && node_ev[id-1]) begin
          push(ST_OK, count, id, 1, n + 1 == count);
          n++;
        end
      end
    endfunction

    function void note(query_item_t it);
      int unsigned cap;
      cap = (it.cap > DEF_MAX_RESULTS) ? DEF_MAX_RESULTS : it.cap;
      case (it.op)
        OP_LOAD_NODE: if (it.slot < DEF_MAX_NODES) begin
          node_ev[it.slot] = it.ev;
          node_first[it.slot] = it.start;
          node_total[it.slot] = it.cnt;
        end
        OP_LOAD_EDGE: edge_mem[it.slot] = it.pref;
        OP_LOAD_STAGE: if (it.slot < DEF_MAX_STAGES) stage_mem[it.slot] = it.snode;
        OP_PARENTS: list_parents(it.key, cap);
        OP_PRED: begin
          for (int i = 0; i < DEF_MAX_NODES; i++) marks[i] = 0;
          if (it.key == 0 || it.key > stage_cnt || it.key > DEF_MAX_STAGES)
            push(ST_NOT_FOUND, 0, 0, 0, 1);
          else if (it.trans) list_ancestors(stage_mem[it.key-1], cap);
          else list_parents(stage_mem[it.key-1], cap);
        end
        default: ;
      endcase
    endfunction

    function void check(res_t got);
      res_t exp;
      if (answer_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
        return;
      end
      exp = answer_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.required !== exp.required) begin
        $error("required: expected %0d actual %0d", exp.required, got.required);
        errors++;
      end
      if (got.item_id !== exp.item_id) begin
        $error("item_id: expected %0d actual %0d", exp.item_id, got.item_id);
        errors++;
      end
      if (got.item_valid !== exp.item_valid) begin
        $error("item_valid: expected %0d actual %0d", exp.item_valid, got.item_valid);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d actual %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  daq_in_if  in_bus();
  daq_out_if out_bus();
  daq_cfg_if cfg_bus();

  dag_ancestor_query_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  lineage_scoreboard sb = new();
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned graph_nodes;
  int unsigned graph_stages;
  int unsigned edge_slots[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("tb_dag_ancestor_query_top NOT OK");
    $finish;
  end

  // Receiver: decide ready at the falling edge, check beats at the rising edge.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.status = out_bus.status;
      got.required = out_bus.required;
      got.item_id = out_bus.item_id;
      got.item_valid = out_bus.item_valid;
      got.last = out_bus.last;
      sb.check(got);
    end
  end

  function automatic query_item_t rand_item();
    query_item_t it;
    it.op = $urandom;
    it.slot = $urandom;
    it.ev = $urandom;
    it.start = $urandom;
    it.cnt = $urandom;
    it.pref = $urandom;
    it.snode = $urandom;
    it.key = $urandom;
    it.trans = $urandom;
    it.cap = $urandom;
    return it;
  endfunction

  task automatic send(query_item_t it);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    in_bus.valid = 1'b1;
    in_bus.operation = it.op;
    in_bus.slot = it.slot;
    in_bus.kind_is_evidence = it.ev;
    in_bus.list_start = it.start;
    in_bus.list_count = it.cnt;
    in_bus.parent_ref = it.pref;
    in_bus.stage_node = it.snode;
    in_bus.query_key = it.key;
    in_bus.transitive = it.trans;
    in_bus.capacity = it.cap;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note(it);
    @(negedge clk_i);
    in_bus.valid = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic ld_edge(int unsigned slot, int unsigned p);
    query_item_t it = rand_item();
    it.op = OP_LOAD_EDGE;
    it.slot = slot;
    it.pref = p;
    edge_slots.push_back(slot);
    send(it);
  endtask

  task automatic ld_node(int unsigned slot, bit ev, int unsigned start, int unsigned cnt);
    query_item_t it = rand_item();
    it.op = OP_LOAD_NODE;
    it.slot = slot;
    it.ev = ev;
    it.start = start;
    it.cnt = cnt;
    send(it);
  endtask

  task automatic ld_stage(int unsigned slot, int unsigned n);
    query_item_t it = rand_item();
    it.op = OP_LOAD_STAGE;
    it.slot = slot;
    it.snode = n;
    send(it);
  endtask

  task automatic ask(logic [OP_W-1:0] op, int unsigned key, bit trans, int unsigned cap);
    query_item_t it = rand_item();
    it.op = op;
    it.key = key;
    it.trans = trans;
    it.cap = cap;
    send(it);
  endtask

  // Hold off until every beat is back and the sequencer has settled.
  task automatic drain();
    while (sb.answer_q.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    while (!in_bus.ready) @(negedge clk_i);
  endtask

  task automatic directed();
    ask(OP_PARENTS, 0, 0, 64);
    ask(OP_PARENTS, 5, 0, 64);
    ask(OP_PRED, 1, 1, 64);
    drain();
    write_reg(REG_NODE_COUNT, 6);
    write_reg(REG_STAGE_COUNT, 4);
    ld_node(0, 1, 0, 0);
    ld_edge(10, 1);
    ld_node(1, 0, 10, 1);
    ld_edge(20, 1);
    ld_edge(21, 2);
    ld_node(2, 1, 20, 2);
    ld_edge(30, 3);
    ld_edge(31, 0);
    ld_edge(32, 1500);
    ld_edge(33, 4);
    ld_node(3, 0, 30, 4);
    ld_edge(40, 4);
    ld_edge(41, 2);
    ld_node(4, 1, 40, 2);
    // list of node 6 wraps past the end of the edge table
    ld_edge(4094, 5);
    ld_edge(4095, 3);
    ld_edge(0, 1);
    ld_node(5, 0, 4094, 3);
    ld_stage(0, 6);
    ld_stage(1, 0);
    ld_stage(2, 9);
    ld_stage(3, 1);
    ask(OP_PARENTS, 6, 0, 64);
    ask(OP_PARENTS, 6, 0, 2);
    ask(OP_PARENTS, 1, 0, 0);
    ask(OP_PARENTS, 7, 0, 64);
    ask(OP_PRED, 1, 1, 127);
    ask(OP_PRED, 1, 1, 1);
    ask(OP_PRED, 1, 0, 64);
    ask(OP_PRED, 2, 1, 64);
    ask(OP_PRED, 3, 1, 64);
    ask(OP_PRED, 4, 1, 64);
    ask(OP_PRED, 5, 1, 64);
    ask(OP_PRED, 0, 0, 64);
    ask(OP_UNKNOWN_LO, 1, 1, 64);
    ask(OP_UNKNOWN_HI, 1, 1, 64);
    ld_node(2000, 1, 0, 4096);
    ld_stage(300, 2047);
    drain();
  endtask

  function automatic int unsigned pick_id(int unsigned limit, int unsigned count);
    int unsigned r = $urandom_range(99);
    if (r < 75 && limit > 0) return $urandom_range(limit, 1);
    if (r < 85) return 0;
    return $urandom_range(2047, count + 1);
  endfunction

  task automatic build_graph(int unsigned ncount);
    int unsigned total;
    int unsigned start;
    int unsigned p;
    edge_slots.delete();
    graph_nodes = $urandom_range(6, 2);
    graph_stages = $urandom_range(3, 1);
    for (int unsigned id = 1; id <= graph_nodes; id++) begin
      total = $urandom_range(2);
      start = $urandom_range(4095);
      for (int unsigned i = 0; i < total; i++) begin
        case ($urandom_range(19))
          0: p = 0;
          1: p = $urandom_range(graph_nodes, id);
          2: p = $urandom_range(2047, 1025);
          default: p = (id > 1) ? $urandom_range(id - 1, 1) : 0;
        endcase
        ld_edge((start + i) % DEF_MAX_EDGES, p);
      end
      ld_node(id - 1, $urandom_range(1), start, total);
    end
    for (int unsigned s = 1; s <= graph_stages; s++) ld_stage(s - 1, pick_id(graph_nodes, ncount));
  endtask

  task automatic random_item();
    query_item_t it = rand_item();
    case ($urandom_range(9))
      0: it.op = $urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO);
      1: begin
        it.op = OP_LOAD_NODE;
        it.slot = $urandom_range(4095, DEF_MAX_NODES);
      end
      2: begin
        it.op = OP_LOAD_STAGE;
        it.slot = $urandom_range(4095, DEF_MAX_STAGES);
      end
      3: if (edge_slots.size() != 0) begin
        it.op = OP_LOAD_EDGE;
        it.slot = edge_slots[$urandom_range(edge_slots.size() - 1)];
      end else it.op = OP_UNKNOWN_LO;
      4, 5, 6: begin
        it.op = OP_PARENTS;
        it.key = pick_id(graph_nodes, sb.node_cnt);
      end
      default: begin
        it.op = OP_PRED;
        it.key = pick_id(graph_stages, sb.stage_cnt);
      end
    endcase
    if ($urandom_range(1)) it.cap = $urandom_range(127, 20);
    send(it);
  endtask

  initial begin
    int unsigned nc;
    int unsigned sc;
    in_bus.valid = 1'b0;
    in_bus.operation = '0;
    in_bus.slot = '0;
    in_bus.kind_is_evidence = 1'b0;
    in_bus.list_start = '0;
    in_bus.list_count = '0;
    in_bus.parent_ref = '0;
    in_bus.stage_node = '0;
    in_bus.query_key = '0;
    in_bus.transitive = 1'b0;
    in_bus.capacity = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    send_idle = 25;
    recv_idle = 54;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    directed();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 25; recv_idle = 54; nc = 1024; sc = 256; end
        1: begin send_idle = 54; recv_idle = 25; nc = $urandom_range(6); sc = $urandom_range(3); end
        default: begin send_idle = 0; recv_idle = 0; nc = 6; sc = 256; end
      endcase
      write_reg(REG_NODE_COUNT, nc);
      write_reg(REG_STAGE_COUNT, sc);
      build_graph(nc);
      for (int i = 0; i < 8; i++) random_item();
      drain();
    end
    if (sb.errors == 0 && sb.answer_q.size() == 0) begin
      $display("tb_dag_ancestor_query_top OK");
    end else begin
      $display("tb_dag_ancestor_query_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/daq_pkg.sv
rtl/core/daq_if.sv
rtl/core/daq_out_reg.sv
rtl/core/dag_ancestor_query_top.sv
verif/tb_dag_ancestor_query_top.sv
